@@ hw/rtl/optq_pkg.sv @@
// Shared types and constants for the one-shot and periodic timer queue.
package optq_pkg;

    // Item kinds carried on s_tuser
    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_ARM_ONCE = 2'd1,
        MODE_ARM_REP  = 2'd2,
        MODE_CANCEL   = 2'd3
    } mode_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ARM_MUL,
        ST_ARM_SUM1,
        ST_ARM_SUM2,
        ST_TICK_ADD,
        ST_SCAN,
        ST_SCAN_END,
        ST_DECIDE,
        ST_FLUSH
    } state_t;

    // Clock advance per tick, in microseconds
    localparam logic [63:0] TICK_US = 64'd1000;
    // Largest valid tick down-count value
    localparam logic [17:0] DOWN_MAX = 18'd167999;

    // x / 168 == ((x >> 3) * RECIP) >> RECIP_SHIFT, exact for x <= DOWN_MAX
    localparam logic [15:0] RECIP = 16'd49933;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W = 30;
    localparam int SUB_W = 10;

    // Firing limit per tick
    localparam int CNT_W = 7;
    localparam logic [CNT_W-1:0] MAX_FIRES = 7'd64;

endpackage

@@ hw/rtl/oneshot_periodic_timer_queue.sv @@
// One-shot and periodic timer queue: microsecond clock, slot store and firing sequencer.
//
// Keeps a 64-bit microsecond clock and up to 16 addressable timer slots
// (min(TIMER_SLOTS,16) slots are stored). s_tuser selects tick, arm one-shot,
// arm repeating or cancel. An arm stores now + elapsed sub-tick microseconds
// + delay as the slot deadline; a tick advances the clock by 1000 us and
// emits one m_ transaction per firing, earliest deadline first, ties to the
// lowest slot, with m_tlast on the last firing of that tick (at most 64).
// A tick with nothing due emits nothing. The block takes one item at a time:
// a cancel completes when it is taken, an arm passes through a multiply and
// two sums, and a tick adds to the clock and then picks every firing by one
// pass over the single-read-port slot memory through one shared comparator.
// Every deadline update goes through one shared 64-bit adder. Output stalls
// add cycles only once a firing is ready to leave.
module oneshot_periodic_timer_queue #(
    parameter int TIMER_SLOTS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // [3:0] timer_id, [35:4] delay_us, [53:36] tick_down_count
    input  logic [1:0]  s_tuser,   // [1:0] mode
    // Result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [3:0] fired_id, [67:4] fire_time_us
    output logic [0:0]  m_tuser,   // [0] fired_repeating
    output logic        m_tlast    // last_fire
);

    // Only 16 slots can be addressed through timer_id
    localparam int USED = (TIMER_SLOTS < 16) ? TIMER_SLOTS : 16;
    localparam int IDX_W = (USED > 1) ? $clog2(USED) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(USED - 1);
    localparam logic [4:0] USED5 = 5'(USED);

    optq_pkg::state_t state_reg, state_next;

    // Latched input item
    optq_pkg::mode_t  mode_reg, mode_next;
    logic [3:0]       id_reg, id_next;
    logic [31:0]      delay_reg, delay_next;
    logic [17:0]      down_reg, down_next;

    // Clock, slot flags and arithmetic temporaries
    logic [63:0]                 now_reg, now_next;
    logic [USED-1:0]             active_reg, active_next;
    logic [optq_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic [63:0]                 acc_reg, acc_next;

    // Scan state
    logic [IDX_W-1:0]           scan_idx_reg, scan_idx_next;
    logic                       cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]           cmp_idx_reg, cmp_idx_next;
    logic                       best_found_reg, best_found_next;
    logic [IDX_W-1:0]           best_id_reg, best_id_next;
    logic [63:0]                best_dl_reg, best_dl_next;
    logic [31:0]                best_iv_reg, best_iv_next;
    logic [optq_pkg::CNT_W-1:0] fire_cnt_reg, fire_cnt_next;

    // Firing held back until the next scan tells whether it is the last
    logic              pend_valid_reg, pend_valid_next;
    logic [IDX_W-1:0]  pend_id_reg, pend_id_next;
    logic              pend_rep_reg, pend_rep_next;
    logic [63:0]       pend_time_reg, pend_time_next;

    // Output register
    logic              m_tvalid_reg, m_tvalid_next;
    logic [3:0]        out_id_reg, out_id_next;
    logic              out_rep_reg, out_rep_next;
    logic [63:0]       out_time_reg, out_time_next;
    logic              out_last_reg, out_last_next;

    // Slot memory
    logic [63:0] dl_mem [USED];
    logic [31:0] iv_mem [USED];
    logic [63:0] rd_dl_reg;
    logic [31:0] rd_iv_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [63:0]      mem_wdl;
    logic [31:0]      mem_wiv;

    // Shared adder
    logic [63:0] add_a, add_b, add_sum;

    logic                 in_acc, out_free, id_ok, cmp_hit;
    logic [IDX_W-1:0]     widx;
    logic [17:0]          down_clamped;
    logic [17:0]          sub_num;
    logic [optq_pkg::SUB_W-1:0] sub_us;

    assign s_tready = (state_reg == optq_pkg::ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign id_ok    = ({1'b0, id_reg} < USED5);
    assign widx     = IDX_W'(id_reg);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'd0, out_time_reg, out_id_reg};
    assign m_tuser  = out_rep_reg;
    assign m_tlast  = out_last_reg;

    // Sub-tick microseconds from the down-count
    assign down_clamped = (down_reg > optq_pkg::DOWN_MAX) ? optq_pkg::DOWN_MAX : down_reg;
    assign sub_num      = optq_pkg::DOWN_MAX - down_clamped;
    assign sub_us       = prod_reg[optq_pkg::RECIP_SHIFT +: optq_pkg::SUB_W];

    // Shared adder operand select
    always_comb begin
        add_a = now_reg;
        add_b = 64'd0;
        case (state_reg)
            optq_pkg::ST_TICK_ADD: begin
                add_a = now_reg;
                add_b = optq_pkg::TICK_US;
            end
            optq_pkg::ST_ARM_SUM1: begin
                add_a = now_reg;
                add_b = {{(64 - optq_pkg::SUB_W){1'b0}}, sub_us};
            end
            optq_pkg::ST_ARM_SUM2: begin
                add_a = acc_reg;
                add_b = {32'd0, delay_reg};
            end
            optq_pkg::ST_DECIDE: begin
                add_a = best_dl_reg;
                add_b = {32'd0, best_iv_reg};
            end
            default: begin
                add_a = now_reg;
                add_b = 64'd0;
            end
        endcase
    end
    assign add_sum = add_a + add_b;

    // Shared comparator: due and earlier than the best so far
    assign cmp_hit = cmp_vld_reg && active_reg[cmp_idx_reg] && (rd_dl_reg <= now_reg)
                     && (!best_found_reg || (rd_dl_reg < best_dl_reg));

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            optq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    case (optq_pkg::mode_t'(s_tuser))
                        optq_pkg::MODE_TICK:     state_next = optq_pkg::ST_TICK_ADD;
                        optq_pkg::MODE_ARM_ONCE: state_next = optq_pkg::ST_ARM_MUL;
                        optq_pkg::MODE_ARM_REP:  state_next = optq_pkg::ST_ARM_MUL;
                        default:                 state_next = optq_pkg::ST_IDLE;
                    endcase
                end
            end
            optq_pkg::ST_ARM_MUL:  state_next = optq_pkg::ST_ARM_SUM1;
            optq_pkg::ST_ARM_SUM1: state_next = optq_pkg::ST_ARM_SUM2;
            optq_pkg::ST_ARM_SUM2: state_next = optq_pkg::ST_IDLE;
            optq_pkg::ST_TICK_ADD: state_next = optq_pkg::ST_SCAN;
            optq_pkg::ST_SCAN: begin
                if (scan_idx_reg == LAST_IDX) state_next = optq_pkg::ST_SCAN_END;
            end
            optq_pkg::ST_SCAN_END: state_next = optq_pkg::ST_DECIDE;
            optq_pkg::ST_DECIDE: begin
                if (best_found_reg) begin
                    if (!pend_valid_reg || out_free) begin
                        if (fire_cnt_reg == optq_pkg::MAX_FIRES - 1'b1) begin
                            state_next = optq_pkg::ST_FLUSH;
                        end else begin
                            state_next = optq_pkg::ST_SCAN;
                        end
                    end
                end else if (pend_valid_reg) begin
                    state_next = optq_pkg::ST_FLUSH;
                end else begin
                    state_next = optq_pkg::ST_IDLE;
                end
            end
            optq_pkg::ST_FLUSH: begin
                if (out_free) state_next = optq_pkg::ST_IDLE;
            end
            default: state_next = optq_pkg::ST_IDLE;
        endcase
    end

    // Datapath and register updates
    always_comb begin
        mode_next       = mode_reg;
        id_next         = id_reg;
        delay_next      = delay_reg;
        down_next       = down_reg;
        now_next        = now_reg;
        active_next     = active_reg;
        prod_next       = prod_reg;
        acc_next        = acc_reg;
        scan_idx_next   = scan_idx_reg;
        cmp_vld_next    = (state_reg == optq_pkg::ST_SCAN);
        cmp_idx_next    = scan_idx_reg;
        best_found_next = best_found_reg;
        best_id_next    = best_id_reg;
        best_dl_next    = best_dl_reg;
        best_iv_next    = best_iv_reg;
        fire_cnt_next   = fire_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        pend_rep_next   = pend_rep_reg;
        pend_time_next  = pend_time_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_id_next     = out_id_reg;
        out_rep_next    = out_rep_reg;
        out_time_next   = out_time_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = best_id_reg;
        mem_wdl         = add_sum;
        mem_wiv         = best_iv_reg;

        // Track the earliest due slot during a scan
        if (cmp_hit) begin
            best_found_next = 1'b1;
            best_id_next    = cmp_idx_reg;
            best_dl_next    = rd_dl_reg;
            best_iv_next    = rd_iv_reg;
        end

        case (state_reg)
            optq_pkg::ST_IDLE: begin
                if (in_acc) begin
                    mode_next  = optq_pkg::mode_t'(s_tuser);
                    id_next    = s_tdata[3:0];
                    delay_next = s_tdata[35:4];
                    down_next  = s_tdata[53:36];
                    // Cancel completes here
                    if ((optq_pkg::mode_t'(s_tuser) == optq_pkg::MODE_CANCEL)
                        && ({1'b0, s_tdata[3:0]} < USED5)) begin
                        active_next[IDX_W'(s_tdata[3:0])] = 1'b0;
                    end
                end
            end
            optq_pkg::ST_ARM_MUL: begin
                prod_next = optq_pkg::PROD_W'(sub_num[17:3])
                            * optq_pkg::PROD_W'(optq_pkg::RECIP);
            end
            optq_pkg::ST_ARM_SUM1: begin
                acc_next = add_sum;
            end
            optq_pkg::ST_ARM_SUM2: begin
                if (id_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = widx;
                    mem_wdl   = add_sum;
                    mem_wiv   = (mode_reg == optq_pkg::MODE_ARM_REP) ? delay_reg : 32'd0;
                    active_next[widx] = 1'b1;
                end
            end
            optq_pkg::ST_TICK_ADD: begin
                now_next        = add_sum;
                scan_idx_next   = '0;
                best_found_next = 1'b0;
                fire_cnt_next   = '0;
            end
            optq_pkg::ST_SCAN: begin
                if (scan_idx_reg != LAST_IDX) scan_idx_next = scan_idx_reg + 1'b1;
            end
            optq_pkg::ST_DECIDE: begin
                if (best_found_reg && (!pend_valid_reg || out_free)) begin
                    // Earlier firing is known not to be the last
                    if (pend_valid_reg) begin
                        m_tvalid_next = 1'b1;
                        out_id_next   = 4'(pend_id_reg);
                        out_rep_next  = pend_rep_reg;
                        out_time_next = pend_time_reg;
                        out_last_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = best_id_reg;
                    pend_rep_next   = (best_iv_reg != 32'd0);
                    pend_time_next  = best_dl_reg;
                    fire_cnt_next   = fire_cnt_reg + 1'b1;
                    // Reschedule or retire the fired slot
                    if (best_iv_reg != 32'd0) begin
                        mem_we    = 1'b1;
                        mem_waddr = best_id_reg;
                        mem_wdl   = add_sum;
                        mem_wiv   = best_iv_reg;
                    end else begin
                        active_next[best_id_reg] = 1'b0;
                    end
                    scan_idx_next   = '0;
                    best_found_next = 1'b0;
                end
            end
            optq_pkg::ST_FLUSH: begin
                if (out_free) begin
                    m_tvalid_next   = 1'b1;
                    out_id_next     = 4'(pend_id_reg);
                    out_rep_next    = pend_rep_reg;
                    out_time_next   = pend_time_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            dl_mem[mem_waddr] <= mem_wdl;
            iv_mem[mem_waddr] <= mem_wiv;
        end
        rd_dl_reg <= dl_mem[scan_idx_reg];
        rd_iv_reg <= iv_mem[scan_idx_reg];
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= optq_pkg::ST_IDLE;
            now_reg        <= 64'd0;
            active_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            fire_cnt_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            active_reg     <= active_next;
            cmp_vld_reg    <= cmp_vld_next;
            pend_valid_reg <= pend_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
            fire_cnt_reg   <= fire_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        id_reg         <= id_next;
        delay_reg      <= delay_next;
        down_reg       <= down_next;
        prod_reg       <= prod_next;
        acc_reg        <= acc_next;
        scan_idx_reg   <= scan_idx_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_found_reg <= best_found_next;
        best_id_reg    <= best_id_next;
        best_dl_reg    <= best_dl_next;
        best_iv_reg    <= best_iv_next;
        pend_id_reg    <= pend_id_next;
        pend_rep_reg   <= pend_rep_next;
        pend_time_reg  <= pend_time_next;
        out_id_reg     <= out_id_next;
        out_rep_reg    <= out_rep_next;
        out_time_reg   <= out_time_next;
        out_last_reg   <= out_last_next;
    end

`ifndef NO_ASSERTIONS
    // No held-back firing may remain once a new item can be taken
    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !pend_valid_reg)
        else $error("pending firing left when returning to idle");

    // Firing count per tick stays within the limit
    a_fire_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        fire_cnt_reg <= optq_pkg::MAX_FIRES)
        else $error("firing count above limit");

    // A chosen firing is always held for the last-flag decision
    a_fire_pends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == optq_pkg::ST_DECIDE && best_found_reg
         && (!pend_valid_reg || out_free)) |=> pend_valid_reg)
        else $error("fired slot not captured");

    // Results only come out of the firing states
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == optq_pkg::ST_DECIDE
                                 || $past(state_reg) == optq_pkg::ST_FLUSH))
        else $error("result raised outside firing states");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the one-shot and periodic timer queue.
module tb;

    localparam int SLOTS       = 16;
    localparam int US_CYCLES   = 168;
    localparam int FIRE_CAP    = 64;
    localparam int RANDOM_CMDS = 350;
    localparam int QUIET_TAIL  = 40;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 1500;
    localparam int STUCK_LIMIT = 5000;

    // One input transaction
    typedef struct packed {
        optq_pkg::mode_t mode;
        logic [3:0]      timer_id;
        logic [31:0]     delay_us;
        logic [17:0]     down_count;
    } timer_cmd_t;

    // One firing on the result channel
    typedef struct packed {
        logic [3:0]  fired_id;
        logic        repeating;
        logic [63:0] fire_time;
        logic        last_fire;
    } firing_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [55:0] s_tdata = '0;
    logic [1:0]  s_tuser = optq_pkg::MODE_TICK;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;

    oneshot_periodic_timer_queue #(.TIMER_SLOTS(SLOTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Stimulus waiting to be offered and firings waiting to arrive
    timer_cmd_t timer_cmds[$];
    firing_t    due_firings[$];
    int         total_cmds;
    int         cmds_done = 0;
    int         errors = 0;

    // Coverage tallies
    int n_ticks = 0, n_arms = 0, n_cancels = 0;
    int n_fired = 0, n_cap_ticks = 0, busiest_tick = 0;

    // Shadow copy of the timer state
    logic [63:0] now_us;
    logic        slot_on   [SLOTS];
    logic [63:0] slot_due  [SLOTS];
    logic [31:0] slot_step [SLOTS];

    // Apply one command to the shadow state and queue the firings it causes
    task automatic schedule_firings(input timer_cmd_t c);
        logic [17:0] dc;
        logic [63:0] sub_us;
        firing_t     burst[FIRE_CAP];
        int          n;
        int          best;
        n = 0;
        case (c.mode)
            optq_pkg::MODE_ARM_ONCE, optq_pkg::MODE_ARM_REP: begin
                // out-of-range down-count clamps to zero elapsed time
                dc = (c.down_count > optq_pkg::DOWN_MAX) ? optq_pkg::DOWN_MAX
                                                         : c.down_count;
                sub_us = 64'(optq_pkg::DOWN_MAX - dc) / US_CYCLES;
                slot_due[c.timer_id]  = now_us + sub_us + 64'(c.delay_us);
                slot_step[c.timer_id] = (c.mode == optq_pkg::MODE_ARM_REP) ? c.delay_us
                                                                            : 32'd0;
                slot_on[c.timer_id]   = 1'b1;
            end
            optq_pkg::MODE_CANCEL: begin
                slot_on[c.timer_id] = 1'b0;
            end
            default: begin
                now_us = now_us + optq_pkg::TICK_US;
                while (n < FIRE_CAP) begin
                    best = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_on[i] && slot_due[i] <= now_us &&
                            (best < 0 || slot_due[i] < slot_due[best]))
                            best = i;
                    end
                    if (best < 0)
                        break;
                    burst[n].fired_id  = 4'(best);
                    burst[n].repeating = (slot_step[best] != 32'd0);
                    burst[n].fire_time = slot_due[best];
                    burst[n].last_fire = 1'b0;
                    if (slot_step[best] != 32'd0)
                        slot_due[best] = slot_due[best] + 64'(slot_step[best]);
                    else
                        slot_on[best] = 1'b0;
                    n++;
                end
                for (int k = 0; k < n; k++) begin
                    burst[k].last_fire = (k == n - 1);
                    due_firings.push_back(burst[k]);
                end
                if (n == FIRE_CAP)
                    n_cap_ticks++;
                if (n > busiest_tick)
                    busiest_tick = n;
            end
        endcase
    endtask

    task automatic queue_cmd(input optq_pkg::mode_t m, input logic [3:0] id,
                             input logic [31:0] dly, input logic [17:0] dc);
        timer_cmd_t c;
        c.mode = m;
        c.timer_id = id;
        c.delay_us = dly;
        c.down_count = dc;
        timer_cmds.push_back(c);
    endtask

    // Driver: offers queued commands, idles in random bursts
    timer_cmd_t offered;
    int         gap_left = 0;
    int         idle_odds = 2;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                schedule_firings(offered);
                cmds_done++;
                case (offered.mode)
                    optq_pkg::MODE_TICK:   n_ticks++;
                    optq_pkg::MODE_CANCEL: n_cancels++;
                    default:               n_arms++;
                endcase
                if (cmds_done % 40 == 0)
                    idle_odds = $urandom_range(0, 3);
            end
            if (s_tvalid && !s_tready) begin
                // hold the offered transaction
            end else begin
                if (gap_left == 0 && idle_odds != 0 && timer_cmds.size() > QUIET_TAIL &&
                    $urandom_range(0, 15) < idle_odds)
                    gap_left = $urandom_range(1, 11);
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (timer_cmds.size() > 0) begin
                    offered = timer_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {2'b00, offered.down_count, offered.delay_us, offered.timer_id};
                    s_tuser  <= offered.mode;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks firings, stalls in bursts, holds off once for long
    firing_t got, want;
    int      stall_left = 0;
    int      stall_odds = 2;
    int      hold_left = 0;
    logic    hold_done = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.fired_id  = m_tdata[3:0];
                got.fire_time = m_tdata[67:4];
                got.repeating = m_tuser[0];
                got.last_fire = m_tlast;
                n_fired++;
                if (n_fired % 50 == 0)
                    stall_odds = $urandom_range(0, 3);
                if (due_firings.size() == 0) begin
                    errors++;
                    $error("unexpected firing: fired_id %0d fire_time_us %0d",
                           got.fired_id, got.fire_time);
                end else begin
                    want = due_firings.pop_front();
                    if (got.fired_id !== want.fired_id) begin
                        errors++;
                        $error("fired_id: expected %0d, actual %0d",
                               want.fired_id, got.fired_id);
                    end
                    if (got.repeating !== want.repeating) begin
                        errors++;
                        $error("fired_repeating: expected %0d, actual %0d",
                               want.repeating, got.repeating);
                    end
                    if (got.fire_time !== want.fire_time) begin
                        errors++;
                        $error("fire_time_us: expected %0d, actual %0d",
                               want.fire_time, got.fire_time);
                    end
                    if (got.last_fire !== want.last_fire) begin
                        errors++;
                        $error("last_fire: expected %0d, actual %0d",
                               want.last_fire, got.last_fire);
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!hold_done && due_firings.size() >= 30) begin
                // long back-pressure so the block fills and blocks its input
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_tready <= 1'b0;
            end else begin
                if (stall_left == 0 && stall_odds != 0 && timer_cmds.size() > QUIET_TAIL &&
                    $urandom_range(0, 15) < stall_odds)
                    stall_left = $urandom_range(1, 11);
                if (stall_left > 0) begin
                    stall_left--;
                    m_tready <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction moves for too long
    int stuck_cycles = 0;

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT) begin
            $error("no transaction for %0d cycles, %0d firings outstanding",
                   stuck_cycles, due_firings.size());
            $display("oneshot_periodic_timer_queue: mismatch");
            $finish;
        end
    end

    // Stimulus, reset and end of run
    timer_cmd_t rc;
    timer_cmd_t last_arm;
    int         pick;

    initial begin
        now_us = '0;
        for (int i = 0; i < SLOTS; i++) begin
            slot_on[i] = 1'b0;
            slot_due[i] = '0;
            slot_step[i] = '0;
        end

        // Directed: empty tick, extremes, ties, re-arm, cancels, firing cap
        queue_cmd(optq_pkg::MODE_TICK,     4'd0,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_ARM_ONCE, 4'd0,  32'd0,         optq_pkg::DOWN_MAX);
        queue_cmd(optq_pkg::MODE_ARM_REP,  4'd15, 32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_ARM_ONCE, 4'd3,  32'hFFFF_FFFF, 18'h3FFFF);
        queue_cmd(optq_pkg::MODE_ARM_REP,  4'd5,  32'd250,       18'd84000);
        queue_cmd(optq_pkg::MODE_ARM_ONCE, 4'd7,  32'd500,       optq_pkg::DOWN_MAX);
        queue_cmd(optq_pkg::MODE_ARM_ONCE, 4'd9,  32'd700,       optq_pkg::DOWN_MAX);
        queue_cmd(optq_pkg::MODE_ARM_ONCE, 4'd2,  32'd700,       optq_pkg::DOWN_MAX);
        queue_cmd(optq_pkg::MODE_ARM_ONCE, 4'd7,  32'd800,       optq_pkg::DOWN_MAX);
        queue_cmd(optq_pkg::MODE_CANCEL,   4'd3,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_CANCEL,   4'd11, 32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_TICK,     4'd15, 32'hFFFF_FFFF, 18'h3FFFF);
        queue_cmd(optq_pkg::MODE_ARM_REP,  4'd1,  32'd1,         optq_pkg::DOWN_MAX);
        queue_cmd(optq_pkg::MODE_ARM_ONCE, 4'd4,  32'h8000_0000, 18'd1);
        queue_cmd(optq_pkg::MODE_TICK,     4'd0,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_TICK,     4'd0,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_CANCEL,   4'd1,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_CANCEL,   4'd5,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_TICK,     4'd0,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_ARM_REP,  4'd6,  32'd2000,      optq_pkg::DOWN_MAX);
        queue_cmd(optq_pkg::MODE_TICK,     4'd0,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_TICK,     4'd0,  32'd0,         18'd0);
        queue_cmd(optq_pkg::MODE_TICK,     4'd0,  32'd0,         18'd0);

        // Random: ticks, arms with mixed delays, cancels
        last_arm = '0;
        for (int k = 0; k < RANDOM_CMDS; k++) begin
            rc.timer_id   = 4'($urandom_range(0, 15));
            rc.delay_us   = $urandom;
            rc.down_count = 18'($urandom_range(0, 18'h3FFFF));
            pick = $urandom_range(0, 99);
            if (pick < 45)
                rc.mode = optq_pkg::MODE_TICK;
            else if (pick < 65)
                rc.mode = optq_pkg::MODE_ARM_ONCE;
            else if (pick < 85)
                rc.mode = optq_pkg::MODE_ARM_REP;
            else
                rc.mode = optq_pkg::MODE_CANCEL;
            if (rc.mode == optq_pkg::MODE_ARM_ONCE || rc.mode == optq_pkg::MODE_ARM_REP) begin
                if ($urandom_range(0, 9) != 0)
                    rc.down_count = 18'($urandom_range(0, optq_pkg::DOWN_MAX));
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    rc.delay_us = 32'($urandom_range(1, 40));
                else if (pick < 3)
                    rc.delay_us = 32'd0;
                else if (pick < 10)
                    rc.delay_us = 32'($urandom_range(0, 600));
                else if (pick < 18)
                    rc.delay_us = 32'($urandom_range(0, 3000));
                // same timing as the previous arm gives deadline ties
                if ($urandom_range(0, 9) == 0) begin
                    rc.delay_us   = last_arm.delay_us;
                    rc.down_count = last_arm.down_count;
                end
                last_arm = rc;
            end
            timer_cmds.push_back(rc);
        end
        total_cmds = timer_cmds.size();

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (!(cmds_done == total_cmds && due_firings.size() == 0))
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);

        if (due_firings.size() != 0)
            $error("%0d expected firings never arrived", due_firings.size());
        $display("Ran %0d commands: %0d ticks, %0d arms, %0d cancels",
                 cmds_done, n_ticks, n_arms, n_cancels);
        $display("Saw %0d firings, up to %0d in one tick, %0d ticks at the cap",
                 n_fired, busiest_tick, n_cap_ticks);
        if (errors == 0 && due_firings.size() == 0)
            $display("oneshot_periodic_timer_queue: match");
        else
            $display("oneshot_periodic_timer_queue: mismatch");
        $finish;
    end

endmodule
